@@ design/bnc_pkg.sv @@
// Shared types, character codes and decode functions for the bracket nesting checker.
package bnc_pkg;

    localparam logic [7:0] CH_NUL    = 8'd0;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_LT     = 8'd60;
    localparam logic [7:0] CH_GT     = 8'd62;
    localparam logic [7:0] CH_LSQ    = 8'd91;
    localparam logic [7:0] CH_RSQ    = 8'd93;
    localparam logic [7:0] CH_LCURLY = 8'd123;
    localparam logic [7:0] CH_RCURLY = 8'd125;

    localparam logic [1:0] BR_PAREN  = 2'd0;
    localparam logic [1:0] BR_SQUARE = 2'd1;
    localparam logic [1:0] BR_CURLY  = 2'd2;
    localparam logic [1:0] BR_ANGLE  = 2'd3;

    localparam logic [1:0] KIND_CORRUPT  = 2'd0;
    localparam logic [1:0] KIND_LINE     = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    localparam int unsigned NUM_CFG = 4;

    localparam logic [1:0] CFG_PENALTY_PAREN  = 2'd0;
    localparam logic [1:0] CFG_PENALTY_SQUARE = 2'd1;
    localparam logic [1:0] CFG_PENALTY_CURLY  = 2'd2;
    localparam logic [1:0] CFG_PENALTY_ANGLE  = 2'd3;

    localparam logic [15:0] PEN_PAREN_RST  = 16'd3;
    localparam logic [15:0] PEN_SQUARE_RST = 16'd57;
    localparam logic [15:0] PEN_CURLY_RST  = 16'd1197;
    localparam logic [15:0] PEN_ANGLE_RST  = 16'd25137;

    localparam logic [63:0] SAT_MAX = {64{1'b1}};

    // One penalty per bracket kind, indexed by bracket code.
    typedef logic [NUM_CFG-1:0][15:0] pen_arr_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] code;
    } br_dec_t;

    function automatic br_dec_t opener_decode(input logic [7:0] c);
        br_dec_t d;
        d = '{hit: 1'b1, code: BR_PAREN};
        case (c)
            CH_LPAREN: d.code = BR_PAREN;
            CH_LSQ:    d.code = BR_SQUARE;
            CH_LCURLY: d.code = BR_CURLY;
            CH_LT:     d.code = BR_ANGLE;
            default:   d.hit  = 1'b0;
        endcase
        return d;
    endfunction

    function automatic br_dec_t closer_decode(input logic [7:0] c);
        br_dec_t d;
        d = '{hit: 1'b1, code: BR_PAREN};
        case (c)
            CH_RPAREN: d.code = BR_PAREN;
            CH_RSQ:    d.code = BR_SQUARE;
            CH_RCURLY: d.code = BR_CURLY;
            CH_GT:     d.code = BR_ANGLE;
            default:   d.hit  = 1'b0;
        endcase
        return d;
    endfunction

endpackage

@@ design/bnc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bnc_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/bnc_cfg.sv @@
// APB-style penalty register file for the bracket nesting checker.
module bnc_cfg
    import bnc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output pen_arr_t    penalties
);

    pen_arr_t   pen_reg;
    logic [1:0] idx;

    assign idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_reg[CFG_PENALTY_PAREN]  <= PEN_PAREN_RST;
            pen_reg[CFG_PENALTY_SQUARE] <= PEN_SQUARE_RST;
            pen_reg[CFG_PENALTY_CURLY]  <= PEN_CURLY_RST;
            pen_reg[CFG_PENALTY_ANGLE]  <= PEN_ANGLE_RST;
        end else if (psel && penable && pwrite) begin
            pen_reg[idx] <= pwdata[15:0];
        end
    end

    assign prdata    = {16'd0, pen_reg[idx]};
    assign penalties = pen_reg;

endmodule

@@ design/bracket_nesting_checker_top.sv @@
// Top level of the bracket nesting checker: stack sequencer around a stack RAM.
//
//   Channel   Direction  Ports                              Transaction
//   s_        in         s_valid s_ready s_ch                one character
//   m_        out        m_valid m_ready m_line_kind ...     one line result
//   apb       in/out     psel penable pwrite paddr pwdata    penalty register
//
// Every character but the line end is accepted in the idle state, then acted on in
// the execute state against the stack top read from the RAM at the accept. The line
// end of a skipped line only clears the level and the skip flag; any other line end
// drains the stack in the drain state, one stack pop per cycle, then emits a result.
// Reset clears the state, the stack level, the skip flag, the running total and the
// output valid flag; the stack RAM needs no clearing pass.
// A result waits in the output register while the next character is accepted;
// the sequencer stalls only when a second result meets an occupied register.
module bracket_nesting_checker_top
    import bnc_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_line_kind,
    output logic [7:0]  m_bad_char,
    output logic [15:0] m_penalty,
    output logic [63:0] m_corrupt_total,
    output logic [63:0] m_completion_score,
    output logic        m_score_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W  = $clog2(STACK_DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    pen_arr_t penalties;

    bnc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .penalties (penalties)
    );

    assign pready = 1'b1;

    logic [1:0]         state_reg, state_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               skip_reg, skip_next;
    logic [63:0]        total_reg, total_next;
    logic [7:0]         ch_reg;
    logic [63:0]        score_reg, score_next;
    logic               sat_reg, sat_next;

    logic               m_valid_reg, m_valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [7:0]         bad_reg, bad_next;
    logic [15:0]        pen_out_reg, pen_out_next;
    logic [63:0]        tot_out_reg, tot_out_next;
    logic [63:0]        scr_out_reg, scr_out_next;
    logic               sat_out_reg, sat_out_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [1:0]         ram_rdata;
    logic [LEVEL_W-1:0] level_m1, level_m2;

    br_dec_t            op_dec, cl_dec;
    logic               out_free, emit;
    logic [64:0]        total_sum;
    logic [63:0]        total_sat;
    logic [15:0]        cl_pen;
    logic [66:0]        score_sum;
    logic [2:0]         digit;

    assign level_m1  = level_reg - LEVEL_W'(1);
    assign level_m2  = level_reg - LEVEL_W'(2);
    // While draining the level drops each cycle, so the next read looks one lower.
    assign ram_raddr = (state_reg == ST_DRAIN) ? level_m2[ADDR_W-1:0]
                                               : level_m1[ADDR_W-1:0];
    assign ram_waddr = level_reg[ADDR_W-1:0];

    bnc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (op_dec.code),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign op_dec    = opener_decode(ch_reg);
    assign cl_dec    = closer_decode(ch_reg);
    assign cl_pen    = penalties[cl_dec.code];
    assign total_sum = {1'b0, total_reg} + {49'd0, cl_pen};
    assign total_sat = total_sum[64] ? SAT_MAX : total_sum[63:0];
    assign digit     = {1'b0, ram_rdata} + 3'd1;
    assign score_sum = {1'b0, score_reg, 2'b00} + {3'b000, score_reg} + {64'd0, digit};
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        level_next   = level_reg;
        skip_next    = skip_reg;
        total_next   = total_reg;
        score_next   = score_reg;
        sat_next     = sat_reg;
        ram_we       = 1'b0;
        emit         = 1'b0;
        kind_next    = kind_reg;
        bad_next     = bad_reg;
        pen_out_next = pen_out_reg;
        tot_out_next = tot_out_reg;
        scr_out_next = scr_out_reg;
        sat_out_next = sat_out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
                if (ch_reg == CH_NUL) begin
                    if (skip_reg) begin
                        level_next = '0;
                        skip_next  = 1'b0;
                    end else begin
                        score_next = '0;
                        sat_next   = 1'b0;
                        state_next = ST_DRAIN;
                    end
                end else if (!skip_reg) begin
                    if (op_dec.hit) begin
                        if (level_reg == LEVEL_W'(STACK_DEPTH)) begin
                            if (out_free) begin
                                emit         = 1'b1;
                                skip_next    = 1'b1;
                                kind_next    = KIND_OVERFLOW;
                                bad_next     = '0;
                                pen_out_next = '0;
                                tot_out_next = total_reg;
                                scr_out_next = '0;
                                sat_out_next = 1'b0;
                            end else begin
                                state_next = ST_EXEC;
                            end
                        end else begin
                            ram_we     = 1'b1;
                            level_next = level_reg + LEVEL_W'(1);
                        end
                    end else if (cl_dec.hit) begin
                        if (level_reg != '0 && ram_rdata == cl_dec.code) begin
                            level_next = level_m1;
                        end else if (out_free) begin
                            emit         = 1'b1;
                            skip_next    = 1'b1;
                            total_next   = total_sat;
                            kind_next    = KIND_CORRUPT;
                            bad_next     = ch_reg;
                            pen_out_next = cl_pen;
                            tot_out_next = total_sat;
                            scr_out_next = '0;
                            sat_out_next = (total_sat == SAT_MAX);
                        end else begin
                            state_next = ST_EXEC;
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (level_reg != '0) begin
                    level_next = level_m1;
                    if (sat_reg || score_sum[66:64] != 3'd0) begin
                        sat_next   = 1'b1;
                        score_next = SAT_MAX;
                    end else begin
                        score_next = score_sum[63:0];
                    end
                end else if (out_free) begin
                    emit         = 1'b1;
                    kind_next    = KIND_LINE;
                    bad_next     = '0;
                    pen_out_next = '0;
                    tot_out_next = total_reg;
                    scr_out_next = score_reg;
                    sat_out_next = sat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            level_reg   <= '0;
            skip_reg    <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            level_reg   <= level_next;
            skip_reg    <= skip_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ch_reg <= s_ch;
        end
        score_reg   <= score_next;
        sat_reg     <= sat_next;
        kind_reg    <= kind_next;
        bad_reg     <= bad_next;
        pen_out_reg <= pen_out_next;
        tot_out_reg <= tot_out_next;
        scr_out_reg <= scr_out_next;
        sat_out_reg <= sat_out_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_line_kind        = kind_reg;
    assign m_bad_char         = bad_reg;
    assign m_penalty          = pen_out_reg;
    assign m_corrupt_total    = tot_out_reg;
    assign m_completion_score = scr_out_reg;
    assign m_score_saturated  = sat_out_reg;

endmodule

@@ design/bnc_checker.sv @@
// Port-level assertions for the bracket nesting checker and their bind.
module bnc_checker
    import bnc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_line_kind,
    input logic [7:0]  m_bad_char,
    input logic [15:0] m_penalty,
    input logic [63:0] m_completion_score,
    input logic        m_score_saturated
);

    // A stalled result stays valid and keeps its kind, bad character, penalty and completion score.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_kind) && $stable(m_bad_char)
            && $stable(m_penalty) && $stable(m_completion_score))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_line_kind == KIND_CORRUPT || m_line_kind == KIND_LINE
            || m_line_kind == KIND_OVERFLOW))
        else $error("unknown line kind");

    // Only a closing bracket can make a line corrupt, and it carries no score.
    a_corrupt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_kind == KIND_CORRUPT |-> m_completion_score == 64'd0
            && (m_bad_char == CH_RPAREN || m_bad_char == CH_RSQ
                || m_bad_char == CH_RCURLY || m_bad_char == CH_GT))
        else $error("malformed corrupt result");

    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_kind == KIND_OVERFLOW |-> m_completion_score == 64'd0
            && !m_score_saturated && m_bad_char == 8'd0 && m_penalty == 16'd0)
        else $error("malformed overflow result");

    a_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_kind == KIND_LINE |-> m_bad_char == 8'd0 && m_penalty == 16'd0)
        else $error("line result carries a penalty");

endmodule

bind bracket_nesting_checker_top bnc_checker u_bnc_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_line_kind        (m_line_kind),
    .m_bad_char         (m_bad_char),
    .m_penalty          (m_penalty),
    .m_completion_score (m_completion_score),
    .m_score_saturated  (m_score_saturated)
);
